// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each use expects signals named clk and
// rst_n in the scope where it stands.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked while reset is released.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/mtws_pkg.sv =====
// ----------------------------------------------------------------------------
// Task watchdog supervisor package
// Table size, operation and status codes, the request struct that passes from
// the sequencer to the entry store, and the result word struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtws_pkg;

  // Number of watched task entries (1 to 64).
  localparam int WATCH_ENTRIES = 8;
  localparam int IDX_W = (WATCH_ENTRIES > 1) ? $clog2(WATCH_ENTRIES) : 1;

  localparam int TIME_W = 32;
  localparam int PER_W  = 16;

  // Entry ids are 8 bits wide on the port; ids at or above this are unknown.
  localparam logic [8:0] ENTRY_LIMIT = 9'(WATCH_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WATCH_ENTRIES - 1);

  localparam logic [PER_W-1:0] PERIOD_RESET = 16'd1000;

  // Operation codes.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_REG    = 3'd1;
  localparam logic [2:0] OP_HBEAT  = 3'd2;
  localparam logic [2:0] OP_SETLIM = 3'd3;
  localparam logic [2:0] OP_PAUSE  = 3'd4;
  localparam logic [2:0] OP_FORCE  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  // Write and read requests toward the entry store.
  typedef struct packed {
    logic              lim_we;
    logic              seen_we;
    logic              act_set;
    idx_t              wr_idx;
    logic [TIME_W-1:0] lim_wdata;
    logic [TIME_W-1:0] seen_wdata;
    idx_t              rd_idx;
  } mem_req_t;

  // One result word.
  typedef struct packed {
    logic [2:0] stale_id;
    logic       stale;
    logic       feed;
    logic       checked;
    logic [2:0] assigned_id;
    logic [1:0] status;
  } result_t;

  // Low three bits of an entry index, as reported on the result port.
  function automatic logic [2:0] id3(input idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[2:0];
  endfunction

endpackage

// ===== hw/rtl/mtws_entry_store.sv =====
// ----------------------------------------------------------------------------
// Task watchdog entry store
// Limit and last-seen memories with registered reads, active flags in
// flip-flops, and the first-free entry search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtws_entry_store (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mtws_pkg::mem_req_t                  req,
  output logic [mtws_pkg::WATCH_ENTRIES-1:0]  active,
  output logic                                free_found,
  output mtws_pkg::idx_t                      free_idx,
  output logic [mtws_pkg::TIME_W-1:0]         rd_lim,
  output logic [mtws_pkg::TIME_W-1:0]         rd_seen
);

  logic [mtws_pkg::TIME_W-1:0] lim_mem  [mtws_pkg::WATCH_ENTRIES];
  logic [mtws_pkg::TIME_W-1:0] seen_mem [mtws_pkg::WATCH_ENTRIES];
  logic [mtws_pkg::TIME_W-1:0] rd_lim_r;
  logic [mtws_pkg::TIME_W-1:0] rd_seen_r;
  logic [mtws_pkg::WATCH_ENTRIES-1:0] active_r;

  // Limit memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.lim_we) begin
      lim_mem[req.wr_idx] <= req.lim_wdata;
    end
    rd_lim_r <= lim_mem[req.rd_idx];
  end

  // Last-seen memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (req.seen_we) begin
      seen_mem[req.wr_idx] <= req.seen_wdata;
    end
    rd_seen_r <= seen_mem[req.rd_idx];
  end

  // Active flags are cleared by reset; an inactive entry's memory rows are
  // never looked at.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (req.act_set) begin
      active_r[req.wr_idx] <= 1'b1;
    end
  end

  // Lowest inactive entry.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = mtws_pkg::WATCH_ENTRIES - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = mtws_pkg::IDX_W'(i);
      end
    end
  end

  assign active  = active_r;
  assign rd_lim  = rd_lim_r;
  assign rd_seen = rd_seen_r;

endmodule

// ===== hw/rtl/mtws_seq.sv =====
// ----------------------------------------------------------------------------
// Task watchdog sequencer
// Decodes each input word, keeps the time and period counters, and walks the
// entry store one entry per cycle for a health check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtws_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          op,
  input  logic [7:0]                          entry_id,
  input  logic [mtws_pkg::TIME_W-1:0]         limit_ms,
  input  logic                                pause_flag,
  input  logic                                cfg_wen,
  input  logic [mtws_pkg::PER_W-1:0]          cfg_wdata,
  output mtws_pkg::mem_req_t                  req,
  input  logic [mtws_pkg::WATCH_ENTRIES-1:0]  active,
  input  logic                                free_found,
  input  mtws_pkg::idx_t                      free_idx,
  input  logic [mtws_pkg::TIME_W-1:0]         rd_lim,
  input  logic [mtws_pkg::TIME_W-1:0]         rd_seen,
  output mtws_pkg::result_t                   res,
  output logic                                res_valid,
  input  logic                                res_take
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                          state_r,  state_nxt;
  logic [mtws_pkg::TIME_W-1:0]   now_r,    now_nxt;
  logic [mtws_pkg::PER_W-1:0]    period_r, period_nxt;
  logic [mtws_pkg::PER_W-1:0]    chk_per_r, chk_per_nxt;
  logic                          paused_r, paused_nxt;
  logic                          forced_r, forced_nxt;
  mtws_pkg::idx_t                scan_idx_r, scan_idx_nxt;
  mtws_pkg::result_t             res_r,    res_nxt;
  logic                          res_vld_r, res_vld_nxt;

  logic                          accept;
  logic [mtws_pkg::PER_W-1:0]    period_inc;
  logic                          due;
  logic                          id_ok;
  mtws_pkg::idx_t                id_idx;
  logic                          id_active;
  logic [mtws_pkg::TIME_W-1:0]   age;
  logic                          hit;
  logic                          last;

  assign in_ready = (state_r == S_IDLE) && !res_vld_r;
  assign accept   = in_valid && in_ready;

  // Period bookkeeping; a zero period acts as one.
  assign period_inc = period_r + 1'b1;
  assign due        = (period_inc >= chk_per_r) || (period_inc == '0);

  // Addressed entry for heartbeat and threshold updates.
  assign id_ok     = {1'b0, entry_id} < mtws_pkg::ENTRY_LIMIT;
  assign id_idx    = entry_id[mtws_pkg::IDX_W-1:0];
  assign id_active = id_ok && active[id_idx];

  // Staleness of the entry whose rows arrive this cycle, on wrapping age.
  assign age  = now_r - rd_seen;
  assign hit  = active[scan_idx_r] && (age > rd_lim);
  assign last = (scan_idx_r == mtws_pkg::LAST_IDX);

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    period_nxt   = period_r;
    chk_per_nxt  = chk_per_r;
    paused_nxt   = paused_r;
    forced_nxt   = forced_r;
    scan_idx_nxt = scan_idx_r;
    res_nxt      = res_r;
    res_vld_nxt  = res_vld_r;
    req          = '0;

    // Read address runs one entry ahead of the compare.
    if (state_r == S_SCAN) begin
      req.rd_idx = last ? '0 : scan_idx_r + 1'b1;
    end

    if (res_take) begin
      res_vld_nxt = 1'b0;
    end

    if (cfg_wen) begin
      chk_per_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt        = '0;
          res_nxt.status = mtws_pkg::ST_DONE;
          res_vld_nxt    = 1'b1;
          case (op)
            mtws_pkg::OP_TICK: begin
              now_nxt = now_r + 1'b1;
              if (due) begin
                period_nxt = '0;
                if (!paused_r && !forced_r) begin
                  // Result comes at the end of the walk.
                  res_vld_nxt  = 1'b0;
                  scan_idx_nxt = '0;
                  state_nxt    = S_SCAN;
                end
              end else begin
                period_nxt = period_inc;
              end
            end
            mtws_pkg::OP_REG: begin
              if (limit_ms == '0) begin
                res_nxt.status = mtws_pkg::ST_ZERO;
              end else if (!free_found) begin
                res_nxt.status = mtws_pkg::ST_FULL;
              end else begin
                req.lim_we          = 1'b1;
                req.seen_we         = 1'b1;
                req.act_set         = 1'b1;
                req.wr_idx          = free_idx;
                req.lim_wdata       = limit_ms;
                req.seen_wdata      = now_r;
                res_nxt.assigned_id = mtws_pkg::id3(free_idx);
              end
            end
            mtws_pkg::OP_HBEAT: begin
              if (id_active) begin
                req.seen_we    = 1'b1;
                req.wr_idx     = id_idx;
                req.seen_wdata = now_r;
              end else begin
                res_nxt.status = mtws_pkg::ST_IGNORED;
              end
            end
            mtws_pkg::OP_SETLIM: begin
              if (id_active && (limit_ms != '0)) begin
                req.lim_we    = 1'b1;
                req.wr_idx    = id_idx;
                req.lim_wdata = limit_ms;
              end else begin
                res_nxt.status = mtws_pkg::ST_IGNORED;
              end
            end
            mtws_pkg::OP_PAUSE: begin
              paused_nxt = pause_flag;
            end
            mtws_pkg::OP_FORCE: begin
              forced_nxt = 1'b1;
            end
            default: begin
              res_nxt.status = mtws_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      S_SCAN: begin
        // The first stale entry ends the walk; otherwise the last one does.
        if (hit || last) begin
          res_nxt          = '0;
          res_nxt.status   = mtws_pkg::ST_DONE;
          res_nxt.checked  = 1'b1;
          res_nxt.stale    = hit;
          res_nxt.feed     = !hit;
          res_nxt.stale_id = hit ? mtws_pkg::id3(scan_idx_r) : 3'd0;
          res_vld_nxt      = 1'b1;
          state_nxt        = S_IDLE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      now_r     <= '0;
      period_r  <= '0;
      chk_per_r <= mtws_pkg::PERIOD_RESET;
      paused_r  <= 1'b0;
      forced_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      now_r     <= now_nxt;
      period_r  <= period_nxt;
      chk_per_r <= chk_per_nxt;
      paused_r  <= paused_nxt;
      forced_r  <= forced_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    res_r      <= res_nxt;
  end

  assign res       = res_r;
  assign res_valid = res_vld_r;

endmodule

// ===== hw/rtl/multi_task_watchdog_supervisor_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-task watchdog supervisor
// Keeps a table of watched tasks and runs periodic health checks over it.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  in_      slave      tvalid / tready    op in tuser, entry and limit in tdata
//  out_     master     tvalid / tready    status and check result in tdata
//  cfg_     write      cfg_wen            check period
//
// Any word but a checked tick has its result written to the sequencer's result
// register when it is taken. A tick that falls due for a check walks up to
// WATCH_ENTRIES entries; the walk stops at the first stale entry, one memory read
// per cycle. The input stalls during the walk and while a result waits in the
// sequencer, until it moves into the output register, so a new word is taken only
// after the last one is through. A stalled output register holds
// one word while the next item is taken; a second result then waits inside
// and stalls the input. Reset is synchronous and clears the active flags at
// once; the memories need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_task_watchdog_supervisor_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // entry_id[7:0], limit_ms[39:8], pause_flag[40]
  input  logic [2:0]  in_tuser,   // op[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[1:0], assigned_id[4:2], checked[5],
                                  // feed[6], stale[7], stale_id[10:8]
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  mtws_pkg::mem_req_t                 req;
  logic [mtws_pkg::WATCH_ENTRIES-1:0] active;
  logic                               free_found;
  mtws_pkg::idx_t                     free_idx;
  logic [mtws_pkg::TIME_W-1:0]        rd_lim;
  logic [mtws_pkg::TIME_W-1:0]        rd_seen;
  mtws_pkg::result_t                  res;
  logic                               res_valid;
  logic                               res_take;
  logic                               out_vld_r;
  logic [15:0]                        out_data_r;

  mtws_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (in_tuser),
    .entry_id   (in_tdata[7:0]),
    .limit_ms   (in_tdata[39:8]),
    .pause_flag (in_tdata[40]),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .active     (active),
    .free_found (free_found),
    .free_idx   (free_idx),
    .rd_lim     (rd_lim),
    .rd_seen    (rd_seen),
    .res        (res),
    .res_valid  (res_valid),
    .res_take   (res_take)
  );

  mtws_entry_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .active     (active),
    .free_found (free_found),
    .free_idx   (free_idx),
    .rd_lim     (rd_lim),
    .rd_seen    (rd_seen)
  );

  // The output register takes a finished result whenever it is empty or drains.
  assign res_take = res_valid && (!out_vld_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= {5'b0, res.stale_id, res.stale, res.feed, res.checked,
                     res.assigned_id, res.status};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hw/rtl/mtws_checker.sv =====
// ----------------------------------------------------------------------------
// Task watchdog port checker
// Watches the result port for words that break the result encoding or the
// stall rule, and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mtws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A stalled result word stays on the port unchanged.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // A check either feeds the watchdog or reports a stale entry, never both.
  `ASSERT_IMPLY(a_check_outcome, out_tvalid && out_tdata[5], out_tdata[6] != out_tdata[7])

  // Without a check the check fields are all clear.
  `ASSERT_IMPLY(a_no_check_clear, out_tvalid && !out_tdata[5], out_tdata[10:6] == 5'd0)

  // Only ticks run checks and only registers assign ids; both end done.
  `ASSERT_IMPLY(a_fail_clear, out_tvalid && (out_tdata[1:0] != mtws_pkg::ST_DONE), out_tdata[10:2] == 9'd0)

endmodule

bind multi_task_watchdog_supervisor_unit mtws_checker u_mtws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
